@@ hw/rtl/pcet_pkg.sv @@
// Shared types, codes and constants of the pair correlation edge table.
`default_nettype none
package pcet_pkg;

  localparam int unsigned EdgeSlotsDef = 256;
  localparam logic [16:0] QOne = 17'h10000;

  localparam logic [1:0] FuncRecord = 2'd0;
  localparam logic [1:0] FuncDecay  = 2'd1;
  localparam logic [1:0] FuncLookup = 2'd2;

  localparam logic [1:0] CfgBoost = 2'd0;
  localparam logic [1:0] CfgDecay = 2'd1;
  localparam logic [1:0] CfgPrune = 2'd2;

  localparam logic [2:0] StUpdated  = 3'd0;
  localparam logic [2:0] StCreated  = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StFound    = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;
  localparam logic [2:0] StDecayed  = 3'd5;

  localparam int unsigned EntryW = 64 + 64 + 17 + 32 + 64;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [16:0] weight;
    logic [31:0] count;
    logic [63:0] step;
  } entry_t;

endpackage
`default_nettype wire

@@ hw/rtl/pcet_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module pcet_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ hw/rtl/pcet_mac.sv @@
// Shared weight unit: boost toward one or decay with prune.
`default_nettype none
module pcet_mac (
  input  wire logic        decay_i,
  input  wire logic [16:0] weight_i,
  input  wire logic [15:0] boost_gain_i,
  input  wire logic [15:0] decay_factor_i,
  input  wire logic [15:0] prune_threshold_i,
  output logic      [16:0] weight_o
);
  import pcet_pkg::*;
  logic [16:0] mul_a;
  logic [15:0] mul_b;
  logic [32:0] prod;
  logic [17:0] sum;
  logic [16:0] scaled;

  always_comb begin
    if (decay_i) begin
      mul_a = weight_i;
      mul_b = decay_factor_i;
    end else begin
      mul_a = (weight_i < QOne) ? 17'(QOne - weight_i) : 17'd0;
      mul_b = boost_gain_i;
    end
    prod   = 33'(mul_a) * 33'(mul_b);
    scaled = prod[32:16];
    sum    = 18'(weight_i) + 18'(scaled);
    if (decay_i) begin
      weight_o = (scaled < 17'(prune_threshold_i)) ? 17'd0 : scaled;
    end else begin
      weight_o = (sum > 18'(QOne)) ? QOne : sum[16:0];
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/pair_correlation_edge_table_core.sv @@
// Top level of the pair correlation edge table.
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | func, ids, step, new_set
//  out     | output    | out_valid/out_ready| status, edge, counters
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
// An item walks the table one slot at a time: S_READ issues the RAM read, S_CHECK compares.
// A miss, a decay and a full table end through S_DONE; a new edge goes on from S_DONE
// to S_WRITE; a lookup hit goes from S_CHECK to S_OUT, a record hit through S_WRITE.
// Reset empties the table at once by zeroing the fill count; no clearing pass.
// A result waits in the output register; the next item is taken once it leaves.
`default_nettype none
module pair_correlation_edge_table_core #(
  parameter int unsigned EdgeSlots = pcet_pkg::EdgeSlotsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [63:0] first_block_i,
  input  wire logic [63:0] second_block_i,
  input  wire logic [63:0] step_now_i,
  input  wire logic        new_set_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [7:0]       edge_index_o,
  output logic [16:0]      edge_weight_o,
  output logic [31:0]      hit_count_o,
  output logic [63:0]      last_seen_step_o,
  output logic [8:0]       live_edges_o,
  output logic [31:0]      retrieval_sets_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import pcet_pkg::*;

  localparam int unsigned AW = $clog2(EdgeSlots);
  localparam int unsigned FW = AW + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_CHECK = 6'b000100,
    S_WRITE = 6'b001000,
    S_DONE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [15:0] boost_q, decay_q, prune_q;
  logic [FW-1:0] fill_q, fill_d;
  logic [31:0] sets_q, sets_d;
  logic [FW-1:0] idx_q, idx_d;
  logic [1:0] func_q;
  logic [63:0] lo_q, hi_q, step_q;
  logic [2:0] st_q, st_d;
  logic [AW-1:0] slot_q, slot_d;
  entry_t ent_q, ent_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata, rdata;
  logic [16:0] mac_w;

  pcet_ram #(.Width(EntryW), .Depth(EdgeSlots)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  pcet_mac u_mac (
    .decay_i(func_q == FuncDecay), .weight_i(rdata.weight),
    .boost_gain_i(boost_q), .decay_factor_i(decay_q),
    .prune_threshold_i(prune_q), .weight_o(mac_w)
  );

  logic swap;
  assign swap = $signed(first_block_i) > $signed(second_block_i);

  always_comb begin
    state_d = state_q; fill_d = fill_q; sets_d = sets_q; idx_d = idx_q;
    st_d = st_q; slot_d = slot_q; ent_d = ent_q;
    we = 1'b0; waddr = slot_q; wdata = ent_q; raddr = idx_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d = '0;
          if (func_i == FuncRecord && new_set_i && sets_q != 32'hFFFFFFFF) begin
            sets_d = sets_q + 32'd1;
          end
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (idx_q >= fill_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (func_q == FuncDecay) begin
          we = 1'b1; waddr = idx_q[AW-1:0];
          wdata = rdata; wdata.weight = mac_w;
          idx_d = idx_q + FW'(1); state_d = S_READ;
        end else if ((func_q == FuncRecord || func_q == FuncLookup)
                     && rdata.lo == lo_q && rdata.hi == hi_q) begin
          slot_d = idx_q[AW-1:0];
          ent_d = rdata;
          if (func_q == FuncLookup) begin
            st_d = StFound; state_d = S_OUT;
          end else begin
            ent_d.weight = mac_w;
            ent_d.step = step_q;
            if (rdata.count != 32'hFFFFFFFF) ent_d.count = rdata.count + 32'd1;
            st_d = StUpdated; state_d = S_WRITE;
          end
        end else begin
          idx_d = idx_q + FW'(1); state_d = S_READ;
        end
      end
      S_WRITE: begin
        we = 1'b1;
        state_d = S_OUT;
      end
      S_DONE: begin
        ent_d = '0; slot_d = '0;
        state_d = S_OUT;
        if (func_q == FuncDecay) begin
          st_d = StDecayed;
        end else if (func_q != FuncRecord) begin
          st_d = StNotFound;
        end else if (fill_q >= FW'(EdgeSlots)) begin
          st_d = StFull;
        end else begin
          slot_d = fill_q[AW-1:0];
          fill_d = fill_q + FW'(1);
          ent_d.lo = lo_q; ent_d.hi = hi_q; ent_d.step = step_q;
          ent_d.count = 32'd1;
          ent_d.weight = 17'((33'(boost_q) << 16) >> 16);
          st_d = StCreated; state_d = S_WRITE;
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      sets_q  <= '0;
      boost_q <= 16'd6554;
      decay_q <= 16'd62259;
      prune_q <= 16'd66;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      sets_q  <= sets_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgBoost: boost_q <= cfg_data_i;
          CfgDecay: decay_q <= cfg_data_i;
          CfgPrune: prune_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; st_q <= st_d; slot_q <= slot_d; ent_q <= ent_d;
    if (state_q == S_IDLE && in_valid_i) begin
      func_q <= func_i;
      step_q <= step_now_i;
      lo_q   <= swap ? second_block_i : first_block_i;
      hi_q   <= swap ? first_block_i : second_block_i;
    end
  end

  assign in_ready_o       = state_q == S_IDLE;
  assign out_valid_o      = state_q == S_OUT;
  assign status_o         = st_q;
  assign edge_index_o     = 8'(slot_q);
  assign edge_weight_o    = ent_q.weight;
  assign hit_count_o      = ent_q.count;
  assign last_seen_step_o = ent_q.step;
  assign live_edges_o     = 9'(fill_q);
  assign retrieval_sets_o = sets_q;
endmodule
`default_nettype wire
